// ----- hw/rtl/sha1_message_hash_unit_macros.svh -----
// Assertion macros for the SHA-1 message hash unit.
// Included by the port checker; depends on nothing else.
`ifndef SHA1_MESSAGE_HASH_UNIT_MACROS_SVH
`define SHA1_MESSAGE_HASH_UNIT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define SMH_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("smh port check failed");

// next-cycle implication, sampled on the rising clock edge
`define SMH_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("smh port check failed");

`endif

// ----- hw/rtl/smh_pkg.sv -----
// Package for the SHA-1 message hash unit: constants, round keys, control types.
// Used by smh_round, smh_core and sha1_message_hash_unit; depends on nothing.
`timescale 1ns / 1ps

package smh_pkg;

  localparam int unsigned NumWords  = 5;
  localparam int unsigned BlockBits = 512;
  localparam int unsigned Rounds    = 80;

  localparam logic [NumWords-1:0][31:0] H_INIT = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [31:0] K_0 = 32'h5A827999;
  localparam logic [31:0] K_1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef struct packed {
    logic start;
    logic init;
  } core_ctrl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } core_stat_t;

endpackage

// ----- hw/rtl/sha1_message_hash_unit.sv -----
// SHA-1 message hash unit, top level: byte packing, padding sequencer, digest output.
// Depends on smh_pkg and smh_core.
//
// Input stream: one transfer carries one message byte in s_axis_tdata_i with
// s_axis_tuser_i low, or a finish command with s_axis_tuser_i high (byte ignored).
// Output stream: one transfer per finish, carrying the five digest words,
// digest_word0 in the lowest 32 bits of m_axis_tdata_o.
// Data bytes are taken one per cycle while s_axis_tready_o is high; the 64th byte
// of a block starts the compression (a start, 80 rounds at one round per cycle in
// the shared round unit, a chaining add), during which s_axis_tready_o is low.
// A finish feeds 9 to 72 padding and length bytes at one per cycle, pausing for
// a compression after each full block (one or two in all), then loads the output
// register and raises m_axis_tvalid_o; the load waits while a digest is held.
// Bytes of the next message are accepted while a digest waits in the output
// register; a second finish holds in the emit step until the receiver takes it.
// Reset clears the length, fill count and handshakes and loads the initial
// chaining values; the unit is ready straight out of reset.
`timescale 1ns / 1ps

module sha1_message_hash_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [7:0] data_byte
  input  logic         s_axis_tuser_i,   // [0] command
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [159:0] m_axis_tdata_o    // [31:0] digest_word0 .. [159:128] digest_word4
);
  import smh_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PAD  = 6'b000010,
    ST_LEN  = 6'b000100,
    ST_COMP = 6'b001000,
    ST_WAIT = 6'b010000,
    ST_EMIT = 6'b100000
  } top_state_e;

  top_state_e st_q, st_d, ret_q, ret_d;
  logic [BlockBits-1:0] blk_q, blk_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] bits_q, bits_d;
  logic [63:0] len_q, len_d;
  logic        first_q, first_d;
  logic [159:0] out_q, out_d;
  logic        ovalid_q, ovalid_d;
  logic        push;
  logic [7:0]  push_byte;
  logic        full;
  logic        s_fire;
  core_ctrl_t  ctrl;
  core_stat_t  stat;
  logic [NumWords-1:0][31:0] hash;

  smh_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .blk_i  (blk_q),
    .stat_o (stat),
    .hash_o (hash)
  );

  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign full   = (fill_q == 6'd63);

  always_comb begin
    st_d      = st_q;
    ret_d     = ret_q;
    bits_d    = bits_q;
    len_d     = len_q;
    first_d   = first_q;
    out_d     = out_q;
    ovalid_d  = ovalid_q;
    push      = 1'b0;
    push_byte = s_axis_tdata_i;
    ctrl      = '0;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      ovalid_d = 1'b0;
    end
    unique case (st_q)
      ST_IDLE: begin
        if (s_fire) begin
          if (s_axis_tuser_i == CMD_ABSORB) begin
            push   = 1'b1;
            bits_d = bits_q + 64'd8;
            if (full) begin
              st_d  = ST_COMP;
              ret_d = ST_IDLE;
            end
          end else begin
            len_d   = bits_q;
            first_d = 1'b1;
            st_d    = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        push      = 1'b1;
        push_byte = first_q ? PAD_BYTE : 8'h00;
        first_d   = 1'b0;
        if (full) begin
          st_d  = ST_COMP;
          ret_d = ST_PAD;
        end else if (fill_q + 6'd1 == LEN_POS) begin
          st_d = ST_LEN;
        end
      end
      ST_LEN: begin
        push      = 1'b1;
        push_byte = len_q[63:56];
        len_d     = {len_q[55:0], 8'h00};
        if (full) begin
          st_d  = ST_COMP;
          ret_d = ST_EMIT;
        end
      end
      ST_COMP: begin
        if (stat.idle) begin
          ctrl.start = 1'b1;
          st_d       = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (stat.done) begin
          st_d = ret_q;
        end
      end
      ST_EMIT: begin
        if (!ovalid_q || m_axis_tready_i) begin
          out_d     = {hash[4], hash[3], hash[2], hash[1], hash[0]};
          ovalid_d  = 1'b1;
          ctrl.init = 1'b1;
          bits_d    = '0;
          st_d      = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
    blk_d  = push ? {blk_q[BlockBits-9:0], push_byte} : blk_q;
    fill_d = push ? fill_q + 6'd1 : fill_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      ret_q    <= ST_IDLE;
      fill_q   <= '0;
      bits_q   <= '0;
      first_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      ret_q    <= ret_d;
      fill_q   <= fill_d;
      bits_q   <= bits_d;
      first_q  <= first_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    len_q <= len_d;
    out_q <= out_d;
  end

  assign s_axis_tready_o = (st_q == ST_IDLE);
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = out_q;

endmodule

// ----- hw/rtl/smh_round.sv -----
// SHA-1 round datapath: boolean function, round key and five-input sum.
// Depends on smh_pkg.
`timescale 1ns / 1ps

module smh_round (
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  input  logic [31:0] d_i,
  input  logic [31:0] e_i,
  input  logic [31:0] w_i,
  input  logic [6:0]  rnd_i,
  output logic [31:0] t_o
);
  import smh_pkg::*;

  logic [31:0] f;
  logic [31:0] k;

  always_comb begin
    priority if (rnd_i < 7'd20) begin
      f = (b_i & c_i) | (~b_i & d_i);
      k = K_0;
    end else if (rnd_i < 7'd40) begin
      f = b_i ^ c_i ^ d_i;
      k = K_1;
    end else if (rnd_i < 7'd60) begin
      f = (b_i & c_i) | (b_i & d_i) | (c_i & d_i);
      k = K_2;
    end else begin
      f = b_i ^ c_i ^ d_i;
      k = K_3;
    end
  end

  assign t_o = {a_i[26:0], a_i[31:27]} + f + e_i + k + w_i;

endmodule

// ----- hw/rtl/smh_core.sv -----
// SHA-1 compression sequencer: one round per cycle over a rolling 16-word window.
// Holds the chaining words. Depends on smh_pkg and smh_round.
`timescale 1ns / 1ps

module smh_core (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  smh_pkg::core_ctrl_t                        ctrl_i,
  input  logic [smh_pkg::BlockBits-1:0]              blk_i,
  output smh_pkg::core_stat_t                        stat_o,
  output logic [smh_pkg::NumWords-1:0][31:0]         hash_o
);
  import smh_pkg::*;

  typedef enum logic [2:0] {
    C_IDLE  = 3'b001,
    C_ROUND = 3'b010,
    C_ADD   = 3'b100
  } core_state_e;

  core_state_e state_q, state_d;
  logic [6:0] rnd_q, rnd_d;
  logic [BlockBits-1:0] win_q, win_d;
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [31:0] a_d, b_d, c_d, d_d, e_d;
  logic [NumWords-1:0][31:0] h_q, h_d;
  logic [31:0] t;
  logic [31:0] sched;

  smh_round u_round (
    .a_i   (a_q),
    .b_i   (b_q),
    .c_i   (c_q),
    .d_i   (d_q),
    .e_i   (e_q),
    .w_i   (win_q[511:480]),
    .rnd_i (rnd_q),
    .t_o   (t)
  );

  assign sched = win_q[95:64] ^ win_q[255:224] ^ win_q[447:416] ^ win_q[511:480];

  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    win_d   = win_q;
    a_d = a_q;
    b_d = b_q;
    c_d = c_q;
    d_d = d_q;
    e_d = e_q;
    h_d = h_q;
    unique case (state_q)
      C_IDLE: begin
        if (ctrl_i.init) begin
          h_d = H_INIT;
        end
        if (ctrl_i.start) begin
          win_d   = blk_i;
          a_d     = h_q[0];
          b_d     = h_q[1];
          c_d     = h_q[2];
          d_d     = h_q[3];
          e_d     = h_q[4];
          rnd_d   = '0;
          state_d = C_ROUND;
        end
      end
      C_ROUND: begin
        a_d   = t;
        b_d   = a_q;
        c_d   = {b_q[1:0], b_q[31:2]};
        d_d   = c_q;
        e_d   = d_q;
        win_d = {win_q[479:0], sched[30:0], sched[31]};
        rnd_d = rnd_q + 7'd1;
        if (rnd_q == 7'(Rounds - 1)) begin
          state_d = C_ADD;
        end
      end
      C_ADD: begin
        h_d[0]  = h_q[0] + a_q;
        h_d[1]  = h_q[1] + b_q;
        h_d[2]  = h_q[2] + c_q;
        h_d[3]  = h_q[3] + d_q;
        h_d[4]  = h_q[4] + e_q;
        state_d = C_IDLE;
      end
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      rnd_q   <= '0;
      h_q     <= H_INIT;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      h_q     <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    a_q   <= a_d;
    b_q   <= b_d;
    c_q   <= c_d;
    d_q   <= d_d;
    e_q   <= e_d;
  end

  assign stat_o.idle = (state_q == C_IDLE);
  assign stat_o.done = (state_q == C_ADD);
  assign hash_o      = h_q;

endmodule

// ----- hw/rtl/smh_checker.sv -----
// Port checker for the SHA-1 message hash unit, bound to the top level.
// Depends on sha1_message_hash_unit_macros.svh.
`timescale 1ns / 1ps
`include "sha1_message_hash_unit_macros.svh"

module smh_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic         s_axis_tuser_i,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [159:0] m_axis_tdata_o
);

  `SMH_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o))
  `SMH_ASSERT_NXT(a_finish_busy, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i, !s_axis_tready_o)
  `SMH_ASSERT_IMP(a_digest_after_busy, clk_i, rst_ni, $rose(m_axis_tvalid_o), !$past(s_axis_tready_o))

endmodule

bind sha1_message_hash_unit smh_checker u_smh_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// ----- dv/tb_top.sv -----
// Testbench for sha1_message_hash_unit: byte stream in, SHA-1 digests out.
// Known digests and a self-contained SHA-1 predictor check every output transfer.
// Depends on smh_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_top;
  import smh_pkg::*;

  typedef bit [4:0][31:0] digest_t;

  typedef struct packed {
    bit      cmd;
    bit [7:0] dbyte;
    bit      typed;
    digest_t want;
  } stim_row_t;

  localparam int unsigned NUM_DIRECTED    = 12;
  localparam int unsigned BYTE_TARGET     = 900;
  localparam int unsigned MIN_MESSAGES    = 20;
  localparam int unsigned WATCHDOG_CYCLES = 3000;
  localparam int unsigned TAIL_CYCLES     = 250;
  localparam int unsigned MAX_REPORTS     = 10;

  localparam bit [4:0][31:0] SHA1_IV = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };
  localparam bit [3:0][31:0] ROUND_K = {
    32'hCA62C1D6, 32'h8F1BBCDC, 32'h6ED9EBA1, 32'h5A827999
  };
  localparam digest_t EMPTY_DIGEST = {
    32'hAFD80709, 32'h95601890, 32'h3255BFEF, 32'h5E6B4B0D, 32'hDA39A3EE
  };
  localparam digest_t ABC_DIGEST = {
    32'h9CD0D89D, 32'h7850C26C, 32'hBA3E2571, 32'h4706816A, 32'hA9993E36
  };

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [7:0]   s_axis_tdata_i = 8'h00;
  logic         s_axis_tuser_i = 1'b0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [159:0] m_axis_tdata_o;

  bit [31:0] hash_h [5];
  bit [31:0] blk_w [16];
  bit [6:0]  fill_cnt;
  bit [63:0] msg_len_bits;

  digest_t   pending_digests [$];
  stim_row_t dir_rows [NUM_DIRECTED];
  int        mismatch_cnt;
  int        transfers_in;
  int        digests_out;
  int        messages;
  int        idle_cycles;
  int        stall_left;
  bit        rx_calm;

  sha1_message_hash_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic void sha1_init();
    for (int i = 0; i < 5; i++) hash_h[i] = SHA1_IV[i];
    for (int i = 0; i < 16; i++) blk_w[i] = '0;
    fill_cnt     = '0;
    msg_len_bits = '0;
  endfunction

  function automatic void sha1_compress();
    bit [31:0] w [16];
    bit [31:0] a, b, c, d, e, f, t, x;
    w = blk_w;
    a = hash_h[0];
    b = hash_h[1];
    c = hash_h[2];
    d = hash_h[3];
    e = hash_h[4];
    for (int i = 0; i < 80; i++) begin
      if (i >= 16) begin
        x = w[(i + 13) % 16] ^ w[(i + 8) % 16] ^ w[(i + 2) % 16] ^ w[i % 16];
        w[i % 16] = {x[30:0], x[31]};
      end
      case (i / 20)
        0: f = (b & c) | (~b & d);
        2: f = (b & c) | (b & d) | (c & d);
        default: f = b ^ c ^ d;
      endcase
      t = {a[26:0], a[31:27]} + f + e + ROUND_K[i / 20] + w[i % 16];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    hash_h[0] += a;
    hash_h[1] += b;
    hash_h[2] += c;
    hash_h[3] += d;
    hash_h[4] += e;
  endfunction

  function automatic void sha1_put_byte(bit [7:0] b);
    int sh;
    sh = (3 - fill_cnt[1:0]) * 8;
    blk_w[fill_cnt[5:2]][sh +: 8] = b;
    fill_cnt++;
    if (fill_cnt == 7'd64) begin
      sha1_compress();
      fill_cnt = '0;
    end
  endfunction

  function automatic digest_t sha1_finish();
    bit [63:0] len;
    digest_t   d;
    len = msg_len_bits;
    sha1_put_byte(8'h80);
    while (fill_cnt != 7'd56) sha1_put_byte(8'h00);
    for (int i = 0; i < 8; i++) sha1_put_byte(len[56 - 8 * i +: 8]);
    for (int i = 0; i < 5; i++) d[i] = hash_h[i];
    sha1_init();
    return d;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic void note_mismatch(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endfunction

  // Enter and leave at a falling edge; valid stays high across back-to-back transfers.
  task automatic send_item(input bit cmd, input bit [7:0] dbyte, input int gap,
                           input bit drain, input bit typed, input digest_t want);
    digest_t d;
    if (drain && gap == 0) gap = 1;
    if (gap > 0) s_axis_tvalid_i <= 1'b0;
    if (drain) begin
      while (pending_digests.size() != 0) @(negedge clk_i);
    end
    repeat (gap) @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= dbyte;
    s_axis_tuser_i  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    transfers_in++;
    if (cmd == CMD_FINISH) begin
      d = sha1_finish();
      pending_digests.push_back(typed ? want : d);
      messages++;
    end else begin
      msg_len_bits += 64'd8;
      sha1_put_byte(dbyte);
    end
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    digest_t want;
    digest_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      digests_out++;
      if (pending_digests.size() == 0) begin
        note_mismatch($sformatf("unexpected digest %h", got));
      end else begin
        want = pending_digests.pop_front();
        for (int i = 0; i < 5; i++) begin
          if (got[i] !== want[i]) begin
            note_mismatch($sformatf("digest %0d word %0d: expected %h, got %h",
                                    digests_out, i, want[i], got[i]));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 299) == 0) rx_calm = !rx_calm;
      if (stall_left > 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (!rx_calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin
    int        len;
    int        r;
    bit        calm;
    bit [7:0]  fill_val;

    dir_rows[0]  = '{CMD_FINISH, 8'h00, 1'b1, EMPTY_DIGEST};
    dir_rows[1]  = '{CMD_ABSORB, 8'h61, 1'b0, '0};
    dir_rows[2]  = '{CMD_ABSORB, 8'h62, 1'b0, '0};
    dir_rows[3]  = '{CMD_ABSORB, 8'h63, 1'b0, '0};
    dir_rows[4]  = '{CMD_FINISH, 8'hFF, 1'b1, ABC_DIGEST};
    dir_rows[5]  = '{CMD_FINISH, 8'hA5, 1'b1, EMPTY_DIGEST};
    dir_rows[6]  = '{CMD_ABSORB, 8'h00, 1'b0, '0};
    dir_rows[7]  = '{CMD_ABSORB, 8'hFF, 1'b0, '0};
    dir_rows[8]  = '{CMD_ABSORB, 8'h80, 1'b0, '0};
    dir_rows[9]  = '{CMD_FINISH, 8'h00, 1'b0, '0};
    dir_rows[10] = '{CMD_ABSORB, 8'hFF, 1'b0, '0};
    dir_rows[11] = '{CMD_FINISH, 8'h7F, 1'b0, '0};

    sha1_init();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].cmd, dir_rows[i].dbyte, pick_gap(), 1'b0,
                dir_rows[i].typed, dir_rows[i].want);
    end

    // Hold the sender until every digest so far has drained.
    send_item(CMD_ABSORB, 8'($urandom_range(0, 255)), 0, 1'b1, 1'b0, '0);
    send_item(CMD_FINISH, 8'($urandom_range(0, 255)), 0, 1'b0, 1'b0, '0);

    while (transfers_in < BYTE_TARGET || messages < MIN_MESSAGES) begin
      r = $urandom_range(0, 99);
      if (r < 40) len = $urandom_range(0, 8);
      else if (r < 70) len = $urandom_range(9, 40);
      else if (r < 90) len = $urandom_range(52, 68);
      else len = $urandom_range(100, 140);
      calm = ($urandom_range(0, 3) == 0);
      fill_val = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      r = $urandom_range(0, 5);
      for (int i = 0; i < len; i++) begin
        send_item(CMD_ABSORB, (r == 0) ? fill_val : 8'($urandom_range(0, 255)),
                  calm ? 0 : pick_gap(), (i == 0) && ($urandom_range(0, 5) == 0),
                  1'b0, '0);
      end
      send_item(CMD_FINISH, 8'($urandom_range(0, 255)), calm ? 0 : pick_gap(),
                1'b0, 1'b0, '0);
    end

    s_axis_tvalid_i <= 1'b0;
    while (pending_digests.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_digests.size() != 0) note_mismatch("digests still outstanding at end");

    $display("Sent %0d input transfers in %0d messages, checked %0d digests,",
             transfers_in, messages, digests_out);
    $display("with random gaps and stalls on both streams; %0d mismatches.", mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
